// File: rtl/core/mrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mrs_pkg;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 8;

  localparam int MEAN_W = 24;
  localparam int VAR_W = 40;
  localparam int STD_W = 24;
  localparam int LABEL_W = 8;

  // Width of the shared divider dividend/quotient.
  localparam int DIV_W = 128;
  localparam int DIVISOR_W = 64;

  localparam logic [1:0] STATUS_NORMAL = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_SINGLE = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] sample;
    logic [7:0] label;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] min_value;
    logic signed [SAMPLE_BITS_DEF-1:0] max_value;
    logic signed [23:0] mean_value;
    logic [39:0] variance_value;
    logic [23:0] std_dev;
    logic [COUNT_BITS_DEF-1:0] voxel_count;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_SNAP,
    ST_MEAN_DIV,
    ST_VAR_MUL,
    ST_VAR_DIV,
    ST_SQRT,
    ST_OUT
  } mrs_state_t;

  typedef struct packed {
    logic accum;
    logic snap;
    logic div_start;
    logic mean_take;
    logic mul_step;
    logic var_load;
    logic var_take;
    logic sqrt_start;
    logic out_load;
  } mrs_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic sqrt_done;
    logic small_count;
  } mrs_stat_t;
endpackage
`default_nettype wire

// File: rtl/core/mrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mrs_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_last,
  output logic in_stall,
  output logic out_valid,
  input  wire logic out_stall,
  input  wire mrs_pkg::mrs_stat_t stat,
  output mrs_pkg::mrs_cmd_t cmd
);
  import mrs_pkg::*;

  mrs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_ACCUM: begin
        if (in_valid && in_last) state_next = ST_SNAP;
      end
      ST_SNAP: begin
        state_next = stat.small_count ? ST_OUT : ST_MEAN_DIV;
      end
      ST_MEAN_DIV: begin
        if (stat.div_done) state_next = ST_VAR_MUL;
      end
      ST_VAR_MUL: begin
        if (stat.mul_done) state_next = ST_VAR_DIV;
      end
      ST_VAR_DIV: begin
        if (stat.div_done) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (stat.sqrt_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) state_next = ST_ACCUM;
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  // Output register: valid is held until the request is taken.
  logic out_valid_next;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_ACCUM: begin
        in_stall = 1'b0;
        cmd.accum = in_valid;
      end
      ST_SNAP: begin
        cmd.snap = 1'b1;
        cmd.div_start = !stat.small_count;
      end
      ST_MEAN_DIV: begin
        cmd.mean_take = stat.div_done;
      end
      ST_VAR_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.var_load = stat.mul_done;
      end
      ST_VAR_DIV: begin
        cmd.var_take = stat.div_done;
        cmd.sqrt_start = stat.div_done;
      end
      ST_SQRT: ;
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_in_only_accum: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> state == ST_ACCUM) else $error("input taken outside accumulation");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall)) else $error("result overwritten");
  a_out_after_last: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid) else $error("result lost");
`endif
endmodule
`default_nettype wire

// File: rtl/core/mrs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module mrs_datapath #(
  parameter int FRAC_BITS = mrs_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [mrs_pkg::LABEL_W-1:0] background_label,
  input  wire mrs_pkg::in_item_t in_item,
  input  wire mrs_pkg::mrs_cmd_t cmd,
  output mrs_pkg::mrs_stat_t stat,
  output mrs_pkg::out_item_t out_item
);
  import mrs_pkg::*;

  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int COUNT_BITS = COUNT_BITS_DEF;
  localparam int SQ_W = 64;
  localparam int SUM_W = 48;
  localparam int MAG_W = SUM_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] run_min, run_max, smp;
  logic signed [SUM_W-1:0] run_sum;
  logic [SQ_W-1:0] run_sq;
  logic [COUNT_BITS-1:0] run_cnt;
  logic [2*SAMPLE_BITS-1:0] sq;
  logic [SQ_W:0] sq_add;
  logic counted;

  assign smp = in_item.sample;
  assign counted = in_item.label != background_label;
  assign sq = (2*SAMPLE_BITS)'($signed(smp) * $signed(smp));
  assign sq_add = {1'b0, run_sq} + {{(SQ_W+1-2*SAMPLE_BITS){1'b0}}, sq};

  // Snapshot registers for the end-of-image math.
  logic signed [SAMPLE_BITS-1:0] snap_min, snap_max;
  logic [COUNT_BITS-1:0] snap_cnt;
  logic snap_neg;
  logic [MAG_W-1:0] snap_mag;
  logic [SQ_W-1:0] snap_sq;

  always_ff @(posedge clk) begin
    if (rst || cmd.snap) begin
      run_min <= SMAX;
      run_max <= SMIN;
      run_sum <= '0;
      run_sq <= '0;
      run_cnt <= '0;
    end else if (cmd.accum && counted) begin
      if (smp < run_min) run_min <= smp;
      if (smp > run_max) run_max <= smp;
      if (run_cnt != COUNT_MAX) begin
        run_cnt <= run_cnt + 1'b1;
        run_sum <= run_sum + SUM_W'(smp);
        run_sq <= sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      snap_min <= run_min;
      snap_max <= run_max;
      snap_cnt <= run_cnt;
      snap_neg <= run_sum[SUM_W-1];
      snap_mag <= run_sum[SUM_W-1] ? MAG_W'(-run_sum) : MAG_W'(run_sum);
      snap_sq <= run_sq;
    end
  end

  assign stat.small_count = run_cnt < COUNT_BITS'(2) && run_cnt == '0;

  // Shared restoring divider, one quotient bit per cycle.
  logic div_busy;
  logic [7:0] div_i;
  logic [DIV_W-1:0] div_n, div_q;
  logic [DIVISOR_W:0] div_r;
  logic [DIVISOR_W-1:0] div_d;
  logic [DIVISOR_W:0] div_sh;
  logic div_go;
  logic [DIV_W-1:0] div_n_in;
  logic [DIVISOR_W-1:0] div_d_in;

  assign div_sh = {div_r[DIVISOR_W-1:0], div_n[DIV_W-1]};
  assign stat.div_done = div_busy && div_i == 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (div_go) begin
      div_busy <= 1'b1;
    end else if (stat.div_done) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_go) begin
      div_n <= div_n_in;
      div_d <= div_d_in;
      div_r <= '0;
      div_q <= '0;
      div_i <= 8'(DIV_W);
    end else if (div_busy && div_i != 8'd0) begin
      div_n <= div_n << 1;
      div_i <= div_i - 1'b1;
      if (div_sh >= {1'b0, div_d}) begin
        div_r <= div_sh - {1'b0, div_d};
        div_q <= {div_q[DIV_W-2:0], 1'b1};
      end else begin
        div_r <= div_sh;
        div_q <= {div_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  // Variance numerator: n*sqsum - mag^2. Both products are built from three 16-bit
  // digits, one digit at a time.
  localparam int PW = 128;
  logic [PW-1:0] acc_a;
  logic [1:0] mul_i;
  logic [15:0] digit;
  logic [15:0] mag_digit;
  logic [SQ_W+15:0] part;
  logic [MAG_W+15:0] mag_part;
  logic [PW-1:0] mag_sq_r;
  logic mul_run;
  logic [DIVISOR_W-1:0] nn1;
  logic [PW-1:0] diff;
  logic [COUNT_BITS-1:0] cnt_m1;

  always_comb begin
    digit = 16'((64'(snap_cnt)) >> (16 * mul_i));
    mag_digit = 16'(snap_mag >> (16 * mul_i));
  end
  assign part = 80'(digit) * 80'(snap_sq);
  assign mag_part = (MAG_W+16)'(mag_digit) * (MAG_W+16)'(snap_mag);
  assign stat.mul_done = mul_run && mul_i == 2'd3;
  assign cnt_m1 = snap_cnt - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_run <= 1'b0;
    end else if (cmd.mean_take) begin
      mul_run <= 1'b1;
    end else if (stat.mul_done) begin
      mul_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_take) begin
      acc_a <= '0;
      mag_sq_r <= '0;
      mul_i <= 2'd0;
    end else if (cmd.mul_step && !stat.mul_done) begin
      acc_a <= acc_a + (PW'(part) << (16 * mul_i));
      mag_sq_r <= mag_sq_r + (PW'(mag_part) << (16 * mul_i));
      mul_i <= mul_i + 1'b1;
      nn1 <= 64'(snap_cnt) * 64'(cnt_m1);
    end
  end

  assign diff = (acc_a < mag_sq_r) ? '0 : acc_a - mag_sq_r;

  always_comb begin
    div_go = cmd.div_start || cmd.var_load;
    if (cmd.var_load) begin
      div_n_in = diff << FRAC_BITS;
      div_d_in = nn1;
    end else begin
      div_n_in = DIV_W'(run_sum[SUM_W-1] ? MAG_W'(-run_sum) : MAG_W'(run_sum)) << FRAC_BITS;
      div_d_in = DIVISOR_W'(run_cnt);
    end
  end

  // Mean and variance results.
  localparam logic [DIV_W-1:0] MLIM_P = DIV_W'((64'd1 << (MEAN_W-1)) - 1);
  localparam logic [DIV_W-1:0] MLIM_N = DIV_W'(64'd1 << (MEAN_W-1));
  localparam logic [DIV_W-1:0] VMAX = DIV_W'((64'd1 << VAR_W) - 1);
  logic signed [MEAN_W-1:0] mean_r;
  logic [VAR_W-1:0] var_r;
  logic [DIV_W-1:0] mq;

  always_comb begin
    if (snap_neg) mq = (div_q > MLIM_N) ? MLIM_N : div_q;
    else mq = (div_q > MLIM_P) ? MLIM_P : div_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      mean_r <= '0;
      var_r <= '0;
    end else begin
      if (cmd.mean_take) mean_r <= snap_neg ? -MEAN_W'(mq) : MEAN_W'(mq);
      if (cmd.var_take) var_r <= (div_q > VMAX) ? VAR_W'(VMAX) : VAR_W'(div_q);
    end
  end

  // Digit-by-digit square root of var << FRAC_BITS, one bit pair a cycle.
  localparam int RW = 64;
  logic [RW-1:0] sq_v, sq_res, sq_bit;
  logic sq_busy;
  logic [RW-1:0] sq_try;
  assign sq_try = sq_res + sq_bit;
  assign stat.sqrt_done = sq_busy && sq_bit == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sq_busy <= 1'b1;
    end else if (stat.sqrt_done) begin
      sq_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_v <= RW'((div_q > VMAX) ? VAR_W'(VMAX) : VAR_W'(div_q)) << FRAC_BITS;
      sq_res <= '0;
      sq_bit <= RW'(1) << (RW - 2);
    end else if (sq_busy && sq_bit != '0) begin
      if (sq_v >= sq_try) begin
        sq_v <= sq_v - sq_try;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  localparam logic [RW-1:0] SMAXD = RW'((64'd1 << STD_W) - 1);
  logic [STD_W-1:0] sd_val;
  assign sd_val = (snap_cnt < COUNT_BITS'(2)) ? '0 :
                  ((sq_res > SMAXD) ? STD_W'(SMAXD) : STD_W'(sq_res));

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.min_value <= snap_min;
      out_item.max_value <= snap_max;
      out_item.mean_value <= mean_r;
      out_item.variance_value <= (snap_cnt < COUNT_BITS'(2)) ? '0 : var_r;
      out_item.std_dev <= sd_val;
      out_item.voxel_count <= snap_cnt;
      out_item.status <= (snap_cnt == '0) ? STATUS_EMPTY :
                         (snap_cnt == COUNT_BITS'(1)) ? STATUS_SINGLE : STATUS_NORMAL;
    end
  end

`ifndef SYNTHESIS
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    run_cnt != '0 |-> run_min <= run_max) else $error("min above max");
  a_div_exclusive: assert property (@(posedge clk) disable iff (rst)
    div_go |-> !div_busy) else $error("divider restarted while busy");
  a_sqrt_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.sqrt_start |-> !sq_busy) else $error("root restarted while busy");
`endif
endmodule
`default_nettype wire

// File: rtl/core/masked_region_statistics.sv
`timescale 1ns / 1ps
`default_nettype none
// Masked region statistics: voxels whose label differs from background_label
// are folded into min, max, count, sum and sum of squares at one request per
// cycle. The request marked last closes the image; the input then stalls for
// a snapshot, the mean on a shared 128-step bit-serial divider, the variance
// numerator, the variance divide, the bit-pair root and the result load.
// Empty images skip the math and go from the snapshot to the result load. A
// result still waiting in the output register delays the next image's result
// load, with the input stalled, until it is taken.
module masked_region_statistics #(
  parameter int FRAC_BITS = mrs_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire mrs_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output mrs_pkg::out_item_t out_data
);
  import mrs_pkg::*;

  logic [LABEL_W-1:0] background_label;
  mrs_cmd_t cmd;
  mrs_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      background_label <= '0;
    end else if (cfg_we) begin
      background_label <= cfg_data;
    end
  end

  mrs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_last(in_data.last),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  mrs_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .background_label(background_label), .in_item(in_data),
    .cmd(cmd), .stat(stat), .out_item(out_data)
  );
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mrs_pkg::*;

  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic signed [15:0] sample;
    logic [7:0] label;
    logic last;
    bit has_fixed;
    out_item_t fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  masked_region_statistics dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [7:0] bg_label;
  logic signed [15:0] acc_min, acc_max;
  logic signed [47:0] acc_sum;
  logic [63:0] acc_sq;
  logic [31:0] acc_count;

  out_item_t pending_stats[$];
  int mismatches = 0;
  bit idle_in = 1'b1;
  bit idle_out = 1'b1;
  bit hold_off = 1'b0;
  bit running = 1'b1;

  function automatic void clear_acc();
    acc_min = 16'sh7fff;
    acc_max = 16'sh8000;
    acc_sum = '0;
    acc_sq = '0;
    acc_count = '0;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Folds one voxel into the running statistics; returns 1 with the image
  // statistics when the request closes an image.
  function automatic bit fold_voxel(in_item_t v, output out_item_t r);
    logic [63:0] mag, sqv, q, lim, n;
    logic [127:0] a, b, d, vq;
    logic [39:0] varv;
    logic [63:0] sd;
    bit neg;
    r = '0;
    if (v.label != bg_label) begin
      if (v.sample < acc_min) acc_min = v.sample;
      if (v.sample > acc_max) acc_max = v.sample;
      if (acc_count != 32'hffff_ffff) begin
        mag = v.sample < 0 ? 64'(-64'sd1 * v.sample) : 64'(v.sample);
        sqv = mag * mag;
        acc_count++;
        acc_sum += v.sample;
        acc_sq = (acc_sq > ~64'd0 - sqv) ? ~64'd0 : acc_sq + sqv;
      end
    end
    if (!v.last) return 0;
    n = acc_count;
    r.min_value = acc_min;
    r.max_value = acc_max;
    r.voxel_count = acc_count;
    if (n == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      neg = acc_sum < 0;
      mag = neg ? 64'(-acc_sum) : 64'(acc_sum);
      q = (mag << FRAC_BITS_DEF) / n;
      lim = neg ? 64'd1 << (MEAN_W - 1) : (64'd1 << (MEAN_W - 1)) - 1;
      if (q > lim) q = lim;
      r.mean_value = neg ? 24'(-q) : 24'(q);
      if (n == 1) begin
        r.status = STATUS_SINGLE;
      end else begin
        r.status = STATUS_NORMAL;
        a = 128'(n) * 128'(acc_sq);
        b = 128'(mag) * 128'(mag);
        varv = 0;
        if (a >= b) begin
          d = (a - b) << FRAC_BITS_DEF;
          vq = d / 128'(n * (n - 1));
          varv = (vq > 128'((64'd1 << VAR_W) - 1)) ? '1 : vq[39:0];
        end
        r.variance_value = varv;
        sd = int_sqrt(64'(varv) << FRAC_BITS_DEF);
        r.std_dev = (sd > 64'hff_ffff) ? 24'hff_ffff : sd[23:0];
      end
    end
    clear_acc();
    return 1;
  endfunction

  task automatic send_voxel(logic signed [15:0] s, logic [7:0] l, logic lst,
                            bit has_fixed = 0, out_item_t fixed = '0);
    in_item_t v;
    out_item_t r;
    v.sample = s;
    v.label = l;
    v.last = lst;
    while (idle_in && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fold_voxel(v, r)) begin
      if (has_fixed && r != fixed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row disagrees with predictor: %h vs %h", fixed, r);
      end
      pending_stats.push_back(r);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_background(logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    bg_label = val;
  endtask

  // Output side: random stalls plus one long hold-off.
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= idle_out && ($urandom_range(99) < 23);
  end

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected statistics %h", out_data);
      end else begin
        e = pending_stats.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected min %0d max %0d mean %0d var %0d sd %0d cnt %0d st %0d; got min %0d max %0d mean %0d var %0d sd %0d cnt %0d st %0d",
                     e.min_value, e.max_value, e.mean_value, e.variance_value, e.std_dev,
                     e.voxel_count, e.status, out_data.min_value, out_data.max_value,
                     out_data.mean_value, out_data.variance_value, out_data.std_dev,
                     out_data.voxel_count, out_data.status);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    row_t rows[$];
    out_item_t f;
    int n_img, len;
    logic [7:0] bgs[4];
    bg_label = 8'd0;
    clear_acc();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; fixed results only where obvious.
    f = '0; f.min_value = 16'sh7fff; f.max_value = 16'sh8000; f.status = STATUS_EMPTY;
    rows.push_back('{16'sd5, 8'd0, 1'b1, 1, f});              // empty image
    f = '0; f.min_value = 16'sh8000; f.max_value = 16'sh8000;
    f.mean_value = 24'sh800000; f.voxel_count = 1; f.status = STATUS_SINGLE;
    rows.push_back('{16'sh8000, 8'hff, 1'b1, 1, f});          // single voxel, most negative
    f = '0; f.min_value = 16'sh7fff; f.max_value = 16'sh7fff;
    f.mean_value = 24'sh7fff00; f.voxel_count = 1; f.status = STATUS_SINGLE;
    rows.push_back('{16'sh7fff, 8'd1, 1'b1, 1, f});
    rows.push_back('{16'sh7fff, 8'd1, 1'b0, 0, f});           // wide spread
    rows.push_back('{16'sh8000, 8'd200, 1'b0, 0, f});
    rows.push_back('{16'sd0, 8'd0, 1'b0, 0, f});              // background, skipped
    rows.push_back('{-16'sd1, 8'd128, 1'b1, 0, f});
    rows.push_back('{16'sd7, 8'd3, 1'b0, 0, f});              // zero variance
    rows.push_back('{16'sd7, 8'd4, 1'b1, 0, f});
    rows.push_back('{-16'sd3, 8'd9, 1'b0, 0, f});             // negative mean
    rows.push_back('{16'sd0, 8'd9, 1'b0, 0, f});
    rows.push_back('{16'sd0, 8'd9, 1'b1, 0, f});
    foreach (rows[i]) send_voxel(rows[i].sample, rows[i].label, rows[i].last,
                                 rows[i].has_fixed, rows[i].fixed);
    drain();

    bgs = '{8'hff, 8'h55, 8'haa, 8'd0};
    for (int phase = 0; phase < 4; phase++) begin
      write_background(bgs[phase]);
      idle_in = (phase != 1);
      idle_out = (phase != 1);
      for (n_img = 0; n_img < 27; n_img++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 60) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          logic signed [15:0] s;
          logic [7:0] l;
          case ($urandom_range(5))
            0: s = 16'(16'sh7fff - $urandom_range(3));
            1: s = 16'(16'sh8000 + $urandom_range(3));
            2: s = 16'($urandom_range(20) - 10);
            default: s = 16'($urandom());
          endcase
          l = ($urandom_range(3) == 0) ? bg_label : 8'($urandom());
          send_voxel(s, l, k == len - 1);
        end
      end
      drain();
    end

    // Long output hold-off while images keep arriving.
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 60; k++) send_voxel(16'($urandom()), 8'($urandom()), k % 4 == 3);
    join
    drain();

    if (mismatches == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
